[design/sra_pkg.sv]
// Shared constants, field widths and controller/datapath interface types.
`default_nettype none
package sra_pkg;

   localparam int unsigned COLS_DEFAULT = 1024;

   localparam int unsigned COL_W     = 10;
   localparam int unsigned VAL_W     = 32;
   localparam int unsigned ACC_W     = 64;
   localparam int unsigned ROW_CNT_W = 11;

   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 88;

   localparam logic FUNC_ACCUM = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef struct packed {
      logic capture;
      logic look;
      logic list_rd;
      logic fetch;
      logic commit;
      logic clear_step;
   } sra_cmd_type;

   typedef struct packed {
      logic is_drain;
      logic drain_has;
      logic clear_done;
      logic out_free;
   } sra_status_type;

endpackage
`default_nettype wire

[design/sra_ctrl.sv]
// Sequencing state machine for the sparse row accumulator.
`default_nettype none
module sra_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire sra_pkg::sra_status_type status,
   output sra_pkg::sra_cmd_type         cmd
);
   import sra_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_LOOK   = 3'd2;
   localparam logic [2:0] ST_LIST   = 3'd3;
   localparam logic [2:0] ST_FETCH  = 3'd4;
   localparam logic [2:0] ST_COMMIT = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            // Captured request decides the path; accumulate reads here.
            if (status.is_drain) begin
               state_in = ST_LIST;
            end else begin
               cmd.look = 1'b1;
               state_in = ST_COMMIT;
            end
         end
         ST_LIST: begin
            if (status.drain_has) begin
               cmd.list_rd = 1'b1;
               state_in    = ST_FETCH;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[design/sra_datapath.sv]
// Column stores, multiplier, saturating adder and result register.
`default_nettype none
module sra_datapath #(
   parameter int unsigned COLS = sra_pkg::COLS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sra_pkg::sra_cmd_type            cmd,
   output sra_pkg::sra_status_type              status,
   input  wire logic [sra_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [sra_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);
   import sra_pkg::*;

   localparam int unsigned IDX_W = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int unsigned CNT_W = $clog2(COLS + 1);

   // Captured request
   logic                    func_ff;
   logic [COL_W-1:0]        col_ff;
   logic signed [VAL_W-1:0] a_ff;
   logic signed [VAL_W-1:0] b_ff;

   logic signed [ACC_W-1:0] prod_ff;

   // Stores
   logic [ACC_W-1:0] acc_mem  [COLS];
   logic             seen_mem [COLS];
   logic [COL_W-1:0] list_mem [COLS];

   logic             seen_q;
   logic [ACC_W-1:0] acc_q;
   logic [COL_W-1:0] list_q;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] pos_ff;
   logic [CNT_W-1:0] pos_in;
   logic [IDX_W-1:0] clr_addr_ff;

   // Result register
   logic                 rsp_valid_ff;
   logic [ROW_CNT_W-1:0] rsp_count_ff;
   logic [COL_W-1:0]     rsp_col_ff;
   logic [ACC_W-1:0]     rsp_value_ff;
   logic                 rsp_flag_ff;
   logic                 rsp_last_ff;

   logic                 in_range;
   logic                 has_room;
   logic                 drain_has;
   logic                 append;
   logic                 acc_we;
   logic [ACC_W-1:0]     acc_wdata;
   logic                 seen_we;
   logic                 seen_wdata;
   logic [IDX_W-1:0]     seen_waddr;
   logic [IDX_W-1:0]     col_idx;
   logic [IDX_W-1:0]     list_idx;
   logic [IDX_W-1:0]     acc_raddr;
   logic signed [ACC_W:0] sum_wide;
   logic [ACC_W-1:0]     sum_sat;
   logic [CNT_W-1:0]     pos_step;
   logic [CNT_W-1:0]     count_out;

   assign col_idx   = IDX_W'(col_ff);
   assign list_idx  = IDX_W'(list_q);
   assign acc_raddr = cmd.fetch ? list_idx : col_idx;
   assign in_range  = 32'(col_ff) < 32'(COLS);
   assign has_room  = count_ff < CNT_W'(COLS);
   assign drain_has = pos_ff < count_ff;

   assign sum_wide = {acc_q[ACC_W-1], acc_q} + {prod_ff[ACC_W-1], prod_ff};
   always_comb begin
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         // Clamp to the nearest limit
         sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[ACC_W-1:0];
      end
   end

   assign append    = cmd.commit && (func_ff == FUNC_ACCUM) && in_range && !seen_q && has_room;
   assign acc_we    = cmd.commit && (func_ff == FUNC_ACCUM) && in_range && (seen_q || has_room);
   assign acc_wdata = seen_q ? sum_sat : prod_ff;

   always_comb begin
      seen_we    = 1'b0;
      seen_wdata = 1'b0;
      seen_waddr = col_idx;
      if (cmd.clear_step) begin
         seen_we    = 1'b1;
         seen_waddr = clr_addr_ff;
      end else if (append) begin
         seen_we    = 1'b1;
         seen_wdata = 1'b1;
      end else if (cmd.commit && (func_ff == FUNC_DRAIN) && drain_has) begin
         seen_we    = 1'b1;
         seen_waddr = list_idx;
      end
   end

   // Capture and product
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_tuser;
         col_ff  <= req_tdata[COL_W-1:0];
         a_ff    <= req_tdata[COL_W+VAL_W-1:COL_W];
         b_ff    <= req_tdata[COL_W+2*VAL_W-1:COL_W+VAL_W];
      end
      if (cmd.look) begin
         prod_ff <= ACC_W'(a_ff * b_ff);
      end
   end

   // Memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[col_idx] <= acc_wdata;
      end
      if (cmd.look || cmd.fetch) begin
         acc_q <= acc_mem[acc_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[seen_waddr] <= seen_wdata;
      end
      if (cmd.look) begin
         seen_q <= seen_mem[col_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (append) begin
         list_mem[count_ff[IDX_W-1:0]] <= col_ff;
      end
      if (cmd.list_rd) begin
         list_q <= list_mem[pos_ff[IDX_W-1:0]];
      end
   end

   // Row bookkeeping
   assign pos_step = drain_has ? pos_ff + CNT_W'(1) : pos_ff;

   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      count_out = count_ff;
      if (append) begin
         count_in  = count_ff + CNT_W'(1);
         count_out = count_in;
      end else if (cmd.commit && (func_ff == FUNC_DRAIN)) begin
         if (pos_step >= count_ff) begin
            count_in = '0;
            pos_in   = '0;
         end else begin
            pos_in = pos_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         pos_ff      <= '0;
         clr_addr_ff <= '0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
         if (cmd.clear_step) begin
            clr_addr_ff <= clr_addr_ff + IDX_W'(1);
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_count_ff <= ROW_CNT_W'(count_out);
         if (func_ff == FUNC_DRAIN) begin
            rsp_col_ff   <= drain_has ? list_q : '0;
            rsp_value_ff <= drain_has ? acc_q : '0;
            rsp_flag_ff  <= drain_has;
            rsp_last_ff  <= pos_step >= count_ff;
         end else begin
            rsp_col_ff   <= '0;
            rsp_value_ff <= '0;
            rsp_flag_ff  <= 1'b0;
            rsp_last_ff  <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W-ROW_CNT_W-COL_W-ACC_W)'(0), rsp_value_ff, rsp_col_ff,
                        rsp_count_ff};

   assign status.is_drain   = (func_ff == FUNC_DRAIN);
   assign status.drain_has  = drain_has;
   assign status.clear_done = (clr_addr_ff == IDX_W'(COLS - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

endmodule
`default_nettype wire

[design/sparse_row_accumulator_unit.sv]
// Sparse row accumulator: top level joining the controller and the datapath.
//
// Request channel (req_*): accumulate requests multiply a_value by b_value (Q16.16)
// into an exact Q32.32 product and add it, saturating, to the sum of col_index;
// a first sighting of a column appends it to the row's column list. Drain
// requests return the next listed column and its sum and forget that entry;
// the final drain of a row raises rsp_tlast and empties the list.
// Response channel (rsp_*): exactly one response per request, in order. Every
// response carries the row's distinct-column count; rsp_tuser marks an entry.
// Sequencing: one request at a time. An accumulate goes through a look and a
// commit step; a drain through look, list read, sum fetch and commit (an empty
// row skips the fetch), set by the registered read of the column stores and, for
// a drain, the list read that must precede the sum read. req_tready rises again
// in the cycle after the response is loaded.
// Reset: synchronous, active high. Afterwards a pass clears the seen flags,
// one column per cycle, over all COLS columns; req_tready stays low meanwhile.
// Stall: a pending response is held in the output register; a finished request
// waits in its commit step until that register frees up.
`default_nettype none
module sparse_row_accumulator_unit #(
   parameter int unsigned COLS = sra_pkg::COLS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata: col_index[9:0], a_value[41:10], b_value[73:42], zero fill
   input  wire logic [sra_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: func (0 accumulate, 1 drain)
   input  wire logic                            req_tuser,
   // Response channel
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: row_count[10:0], out_column[20:11], out_value[84:21], zero fill
   output logic [sra_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // tuser: out_valid
   output logic                                 rsp_tuser,
   // tlast: out_last
   output logic                                 rsp_tlast
);
   import sra_pkg::*;

   sra_cmd_type    cmd;
   sra_status_type status;

   sra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sra_datapath #(
      .COLS (COLS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // One request in flight: no second accept right after one.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   // A response without an entry carries zero column and value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[84:11] == 74'd0))
      else $error("entry fields nonzero on response without entry");

   // A response appears only as a new load, never while idle-ready.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !req_tready || $past(req_tready) == 1'b0)
      else $error("response loaded without a request in progress");

endmodule
`default_nettype wire

[tb/tb_sparse_row_accumulator_unit.sv]
// Testbench for the sparse row accumulator: self-checking, directed rows plus random rows.
`default_nettype none
module tb_sparse_row_accumulator_unit;
   import sra_pkg::*;

   localparam int unsigned COLS = COLS_DEFAULT;
   localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;
   localparam int RANDOM_ITEMS = 1620;

   typedef struct {
      logic [ROW_CNT_W-1:0] row_count;
      logic [COL_W-1:0]     column;
      logic [ACC_W-1:0]     value;
      logic                 entry_valid;
      logic                 row_last;
   } row_result_type;

   // Tracks one output row the way the block should, and holds the responses still owed.
   class row_scoreboard;
      bit                  seen[COLS];
      longint              sums[COLS];
      logic [COL_W-1:0]    col_list[COLS];
      int unsigned         entries;
      int unsigned         drain_pos;
      row_result_type      owed_q[$];
      int                  failures;
      int                  n_accum, n_drain, n_sat, n_drop, n_rows;

      function new();
         entries = 0;
         drain_pos = 0;
         failures = 0;
         n_accum = 0; n_drain = 0; n_sat = 0; n_drop = 0; n_rows = 0;
         foreach (seen[i]) seen[i] = 1'b0;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void note_request(logic func, logic [COL_W-1:0] col,
                                 logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
         row_result_type r;
         longint      prod;
         longint      acc;
         int unsigned c;
         r.column = '0;
         r.value = '0;
         r.entry_valid = 1'b0;
         r.row_last = 1'b0;
         if (func == FUNC_ACCUM) begin
            n_accum++;
            c = col;
            if (c < COLS) begin
               prod = longint'(signed'(a)) * longint'(signed'(b));
               if (seen[c]) begin
                  acc = sums[c];
                  if (prod > 0 && acc > SUM_MAX - prod) begin
                     sums[c] = SUM_MAX;
                     n_sat++;
                  end else if (prod < 0 && acc < SUM_MIN - prod) begin
                     sums[c] = SUM_MIN;
                     n_sat++;
                  end else begin
                     sums[c] = acc + prod;
                  end
               end else if (entries < COLS) begin
                  seen[c] = 1'b1;
                  col_list[entries] = col;
                  entries++;
                  sums[c] = prod;
               end else begin
                  n_drop++;
               end
            end
            r.row_count = ROW_CNT_W'(entries);
         end else begin
            n_drain++;
            r.row_count = ROW_CNT_W'(entries);
            if (drain_pos < entries) begin
               c = col_list[drain_pos];
               r.column = col_list[drain_pos];
               r.value = sums[c];
               r.entry_valid = 1'b1;
               sums[c] = 0;
               seen[c] = 1'b0;
               drain_pos++;
            end
            if (drain_pos >= entries) begin
               r.row_last = 1'b1;
               entries = 0;
               drain_pos = 0;
               n_rows++;
            end
         end
         owed_q.push_back(r);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data, logic user, logic last);
         row_result_type w;
         row_result_type g;
         g.row_count = data[10:0];
         g.column = data[20:11];
         g.value = data[84:21];
         g.entry_valid = user;
         g.row_last = last;
         if (owed_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("response with nothing owed: count %0d col %0d value %h valid %b last %b",
                        g.row_count, g.column, g.value, g.entry_valid, g.row_last);
            return;
         end
         w = owed_q.pop_front();
         if (g.row_count !== w.row_count || g.column !== w.column || g.value !== w.value
             || g.entry_valid !== w.entry_valid || g.row_last !== w.row_last) begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch at %0t: expected count %0d col %0d value %h valid %b last %b",
                        $time, w.row_count, w.column, w.value, w.entry_valid, w.row_last);
               $display("                 got      count %0d col %0d value %h valid %b last %b",
                        g.row_count, g.column, g.value, g.entry_valid, g.row_last);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = FUNC_ACCUM;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   row_scoreboard sb = new();
   int send_idle = 8;
   int recv_idle = 87;
   int hold_cycles = 0;
   int items_sent = 0;

   sparse_row_accumulator_unit #(.COLS(COLS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("timeout: %0d responses still owed", sb.pending());
      $display("RESULT: ERROR");
      $finish;
   end

   // Receiver: check accepted responses, stall at random or for a requested hold.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
            sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   task automatic send_request(input logic func, input logic [COL_W-1:0] col,
                               input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
      if ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {6'b0, b, a, col};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(func, col, a, b);
      items_sent++;
   endtask

   task automatic send_drain();
      send_request(FUNC_DRAIN, COL_W'($urandom_range(0, COLS - 1)), $urandom, $urandom);
   endtask

   // Drain until the row ends; an empty row still takes one drain.
   task automatic drain_row();
      do send_drain(); while (sb.entries != 0);
   endtask

   function automatic logic [VAL_W-1:0] pick_operand();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 60) return $urandom;
      if (kind < 85) return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      case ($urandom_range(0, 3))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Mostly small rows with repeated columns, now and then a drain in the middle.
   task automatic random_row();
      logic [COL_W-1:0] pool[40];
      int ncols;
      int n_acc;
      ncols = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      for (int i = 0; i < ncols; i++) pool[i] = COL_W'($urandom_range(0, COLS - 1));
      n_acc = $urandom_range(ncols, 3 * ncols);
      for (int k = 0; k < n_acc; k++) begin
         if ($urandom_range(0, 9) == 0)
            send_drain();
         else
            send_request(FUNC_ACCUM, pool[$urandom_range(0, ncols - 1)],
                         pick_operand(), pick_operand());
      end
      drain_row();
   endtask

   task automatic random_phase(input int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 99) < 85)
            random_row();
         else
            send_request(1'($urandom_range(0, 1)), COL_W'($urandom_range(0, COLS - 1)),
                         $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty row, operand extremes, saturation both ways, re-accumulate while draining.
      send_drain();
      send_request(FUNC_ACCUM, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      repeat (3) send_request(FUNC_ACCUM, 10'd1023, 32'h8000_0000, 32'h8000_0000);
      repeat (3) send_request(FUNC_ACCUM, 10'd512, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(FUNC_ACCUM, 10'd0, 32'h0000_0000, 32'h1234_5678);
      send_drain();
      send_request(FUNC_ACCUM, 10'd0, 32'hFFFF_FFFF, 32'h0001_0000);
      repeat (3) send_drain();
      send_drain();
      send_request(FUNC_ACCUM, 10'h2AA, 32'h5555_5555, 32'hAAAA_AAAA);
      send_request(FUNC_ACCUM, 10'h155, 32'hAAAA_AAAA, 32'h5555_5555);
      send_request(FUNC_ACCUM, 10'h2AA, 32'hFFFF_FFFF, 32'h0000_0001);
      drain_row();

      random_phase(RANDOM_ITEMS / 3);

      // Pause the sender until every owed response is back.
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);

      send_idle = 87;
      recv_idle = 8;
      random_phase(RANDOM_ITEMS / 3);

      send_idle = 0;
      recv_idle = 0;
      hold_cycles = 300;
      random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d requests: %0d accumulates (%0d saturated, %0d dropped on a full list),",
               items_sent, sb.n_accum, sb.n_sat, sb.n_drop);
      $display("%0d drains closing %0d rows; %0d failures.", sb.n_drain, sb.n_rows, sb.failures);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
